/* rtl/core/type_length_frame_decoder_defines.svh */
// Assertion macros for the type-length frame decoder checks.
// Used by tlfd_checker.sv; expects aclk and aresetn in scope.
`ifndef TYPE_LENGTH_FRAME_DECODER_DEFINES_SVH
`define TYPE_LENGTH_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define TLFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define TLFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tlfd_pkg.sv */
// Shared types and constants of the type-length frame decoder.
// No dependencies; used by the top level and its checker.
`default_nettype none

package tlfd_pkg;

    localparam int unsigned HDR_BYTES = 6;
    localparam logic [2:0] HDR_LAST_IDX = 3'(HDR_BYTES - 1);
    localparam logic [31:0] DEFAULT_MAX_BODY = 32'(10 * 1024 * 1024);

    // config space: one 32-bit register at byte offset 0
    localparam int unsigned PADDR_W = 3;
    localparam logic REG_MAX_BODY_LENGTH = 1'b0;

    // result kinds
    localparam logic [1:0] KIND_HEADER   = 2'd0;
    localparam logic [1:0] KIND_BODY     = 2'd1;
    localparam logic [1:0] KIND_SIZE_ERR = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_ERROR  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] message_type;
        logic [31:0] body_length;
        logic [7:0]  body_byte;
        logic        end_of_message;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/type_length_frame_decoder.sv */
// Type-length frame decoder: top level, input and result registers, framing logic.
// Depends on tlfd_pkg.sv.
//
// Splits a received byte stream into messages. Each message starts with a
// six-byte header: a big-endian 16-bit type, then a big-endian 32-bit body
// length. After the sixth header byte one header transaction goes out (kind
// header, marked end_of_message when the length is zero), then one body
// transaction per body byte, the last one marked end_of_message. A length
// above max_body_length gives one size-error transaction carrying the length;
// the decoder then drops every byte until reset. Throughput is one byte per
// clock while the result is accepted; a byte is held in the input register
// and its result in the result register that drives the m_ port. The framing
// step is one 32-bit compare and one 32-bit decrement between the input
// register and the result register. Input and result registers each hold one
// transaction: while a result waits for m_ready, one more byte is taken into
// the input register, then s_ready stays low until the result is accepted.
// max_body_length (offset 0x0) resets to 10 MiB; the user writes it only while
// the decoder is idle (not enforced); a new value applies from the next header.
`default_nettype none

module type_length_frame_decoder (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // byte stream in
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [7:0]                  s_stream_byte,
    // results out
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [1:0]                       m_result_kind,
    output logic [15:0]                      m_message_type,
    output logic [31:0]                      m_body_length,
    output logic [7:0]                       m_body_byte,
    output logic                             m_end_of_message,
    // APB-style config port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tlfd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    // config
    logic [31:0] max_len_reg;

    // input register
    logic        in_vld_reg, in_vld_next;
    logic [7:0]  in_byte_reg;

    // framing state
    tlfd_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [39:0] hdr_shift_reg, hdr_shift_next;
    logic [31:0] left_reg, left_next;

    // result register
    logic              out_vld_reg, out_vld_next;
    tlfd_pkg::result_t res_reg, res_next;
    logic              res_produced;

    logic        advance;   // result slot is free or being drained
    logic        take;      // byte in input register is processed this cycle
    logic [31:0] hdr_len;
    logic [15:0] hdr_type;

    assign advance = !out_vld_reg || m_ready;
    assign take    = in_vld_reg && advance;
    assign s_ready = !in_vld_reg || advance;

    assign hdr_len  = {hdr_shift_reg[23:0], in_byte_reg};
    assign hdr_type = hdr_shift_reg[39:24];

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == tlfd_pkg::REG_MAX_BODY_LENGTH) ? max_len_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= tlfd_pkg::DEFAULT_MAX_BODY;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == tlfd_pkg::REG_MAX_BODY_LENGTH) begin
            max_len_reg <= pwdata;
        end
    end

    // ---------------- input register ----------------
    always_comb begin
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (take) begin
            in_vld_next = 1'b0;
        end else begin
            in_vld_next = in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_stream_byte;
        end
    end

    // ---------------- framing: next state ----------------
    always_comb begin
        phase_next     = phase_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        hdr_shift_next = hdr_shift_reg;
        left_next      = left_reg;
        if (take) begin
            case (phase_reg)
                tlfd_pkg::PH_ERROR: begin
                    // sticky: drop everything
                end
                tlfd_pkg::PH_BODY: begin
                    if (left_reg <= 32'd1) begin
                        left_next  = 32'd0;
                        phase_next = tlfd_pkg::PH_HEADER;
                    end else begin
                        left_next = left_reg - 32'd1;
                    end
                end
                default: begin
                    // header phase; the spare phase code behaves the same
                    phase_next = tlfd_pkg::PH_HEADER;
                    if (hdr_cnt_reg < tlfd_pkg::HDR_LAST_IDX) begin
                        hdr_shift_next = {hdr_shift_reg[31:0], in_byte_reg};
                        hdr_cnt_next   = hdr_cnt_reg + 3'd1;
                    end else begin
                        hdr_cnt_next   = 3'd0;
                        hdr_shift_next = 40'd0;
                        if (hdr_len > max_len_reg) begin
                            phase_next = tlfd_pkg::PH_ERROR;
                        end else if (hdr_len != 32'd0) begin
                            left_next  = hdr_len;
                            phase_next = tlfd_pkg::PH_BODY;
                        end
                    end
                end
            endcase
        end
    end

    // ---------------- framing: result ----------------
    always_comb begin
        res_produced = 1'b0;
        res_next     = '0;
        case (phase_reg)
            tlfd_pkg::PH_ERROR: begin
                res_produced = 1'b0;
            end
            tlfd_pkg::PH_BODY: begin
                res_produced            = 1'b1;
                res_next.kind           = tlfd_pkg::KIND_BODY;
                res_next.body_byte      = in_byte_reg;
                res_next.end_of_message = (left_reg <= 32'd1);
            end
            default: begin
                if (hdr_cnt_reg >= tlfd_pkg::HDR_LAST_IDX) begin
                    res_produced         = 1'b1;
                    res_next.body_length = hdr_len;
                    if (hdr_len > max_len_reg) begin
                        res_next.kind = tlfd_pkg::KIND_SIZE_ERR;
                    end else begin
                        res_next.kind           = tlfd_pkg::KIND_HEADER;
                        res_next.message_type   = hdr_type;
                        res_next.end_of_message = (hdr_len == 32'd0);
                    end
                end
            end
        endcase
    end

    always_comb begin
        if (take) begin
            out_vld_next = res_produced;
        end else if (advance) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= tlfd_pkg::PH_HEADER;
            hdr_cnt_reg   <= 3'd0;
            hdr_shift_reg <= 40'd0;
            left_reg      <= 32'd0;
            out_vld_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            hdr_shift_reg <= hdr_shift_next;
            left_reg      <= left_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && res_produced) begin
            res_reg <= res_next;
        end
    end

    assign m_valid          = out_vld_reg;
    assign m_result_kind    = res_reg.kind;
    assign m_message_type   = res_reg.message_type;
    assign m_body_length    = res_reg.body_length;
    assign m_body_byte      = res_reg.body_byte;
    assign m_end_of_message = res_reg.end_of_message;

endmodule

`default_nettype wire

/* rtl/core/tlfd_checker.sv */
// Port-level checks for the type-length frame decoder, bound to the top level.
// Depends on tlfd_pkg.sv and type_length_frame_decoder_defines.svh.
`default_nettype none

`include "type_length_frame_decoder_defines.svh"

module tlfd_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [1:0]                    m_result_kind,
    input wire logic [15:0]                   m_message_type,
    input wire logic [31:0]                   m_body_length,
    input wire logic [7:0]                    m_body_byte,
    input wire logic                          m_end_of_message
);

    logic [58:0] m_payload;
    logic        err_taken;
    logic        hdr_shown;
    logic        unused_zero;

    assign m_payload = {m_result_kind, m_message_type, m_body_length, m_body_byte,
                        m_end_of_message};
    assign err_taken = m_valid && m_ready && (m_result_kind == tlfd_pkg::KIND_SIZE_ERR);
    assign hdr_shown = m_valid && (m_result_kind == tlfd_pkg::KIND_HEADER);

    // body: no type, no length; size error: no type, no byte, no end flag
    always_comb begin
        if (m_result_kind == tlfd_pkg::KIND_BODY) begin
            unused_zero = (m_message_type == 16'd0) && (m_body_length == 32'd0);
        end else begin
            unused_zero = (m_message_type == 16'd0) && (m_body_byte == 8'd0) &&
                          !m_end_of_message;
        end
    end

    // stalled result holds
    `TLFD_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_payload), "result changed while stalled")

    // nothing follows a delivered size error
    `TLFD_ASSERT_NEXT(a_err_sticky, err_taken, !m_valid, "result after size error")

    // header marks end of message exactly for empty bodies
    `TLFD_ASSERT_NOW(a_hdr_eom, hdr_shown, m_end_of_message == !(|m_body_length), "header end flag wrong")

    // error and body transactions carry zeroed unused fields
    `TLFD_ASSERT_NOW(a_unused_zero, m_valid && !hdr_shown, unused_zero, "unused field not zero")

endmodule

bind type_length_frame_decoder tlfd_checker u_tlfd_checker (.*);

`default_nettype wire
